// ----- hw/rtl/pid_controller_clamped_core_macros.svh -----
// Assertion macros shared by the checker of the clamped PID controller.
`ifndef PID_CONTROLLER_CLAMPED_CORE_MACROS_SVH
`define PID_CONTROLLER_CLAMPED_CORE_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define PIDC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define PIDC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that stays live during reset.
`define PIDC_ASSERT_RST(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/pidc_pkg.sv -----
// Shared types and constants of the clamped PID controller.
`default_nettype none

package pidc_pkg;

    localparam int DIV_W     = 48;
    localparam int DIV_STEPS = DIV_W / 2;

    localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [2:0] REG_DERIV_GAIN  = 3'd2;
    localparam logic [2:0] REG_SETPOINT    = 3'd3;
    localparam logic [2:0] REG_DRIVE_LIMIT = 3'd4;

    localparam logic signed [31:0] INTEG_LIMIT = 32'sd6553600;
    localparam logic [30:0]        LIMIT_RESET = 31'd707789;
    localparam logic [15:0]        MS_PER_S    = 16'd1000;
    localparam logic signed [31:0] S32_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN     = 32'sh8000_0000;

    localparam logic [1:0] GAIN_P = 2'd0;
    localparam logic [1:0] GAIN_I = 2'd1;
    localparam logic [1:0] GAIN_D = 2'd2;

    localparam logic DIV_INTEG = 1'b0;
    localparam logic DIV_DERIV = 1'b1;

    typedef struct packed {
        logic       load_in;
        logic       calc_err;
        logic       calc_prods;
        logic       div_start;
        logic       div_sel;
        logic       integ_upd;
        logic       deriv_upd;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       acc_ld;
        logic       acc_add;
        logic       clamp_en;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic dt_zero;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pidc_div.sv -----
// Unsigned restoring divider, two quotient bits per cycle.
`default_nettype none

module pidc_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [pidc_pkg::DIV_W-1:0] dividend,
    input  wire logic [15:0]               divisor,
    output logic                           done,
    output logic [pidc_pkg::DIV_W-1:0]     quotient
);
    import pidc_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic [DIV_W-1:0] quo_reg;
    logic [15:0]      rem_reg;
    logic [15:0]      divisor_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;

    logic [16:0] t1, t2;
    logic [15:0] r1, r2;
    logic        q1, q0;

    always_comb begin
        t1 = {rem_reg, quo_reg[DIV_W-1]};
        q1 = (t1 >= {1'b0, divisor_reg});
        r1 = q1 ? 16'(t1 - {1'b0, divisor_reg}) : t1[15:0];
        t2 = {r1, quo_reg[DIV_W-2]};
        q0 = (t2 >= {1'b0, divisor_reg});
        r2 = q0 ? 16'(t2 - {1'b0, divisor_reg}) : t2[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIV_STEPS - 1);
        end else if (run_reg) begin
            if (cnt_reg == '0) begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end else begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end else if (run_reg) begin
            quo_reg <= {quo_reg[DIV_W-3:0], q1, q0};
            rem_reg <= r2;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/pidc_dpath.sv -----
// Datapath of the clamped PID controller: registers, state, products and clamps.
`default_nettype none

module pidc_dpath (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [31:0]       cfg_wdata,
    input  wire logic [47:0]       s_tdata,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [31:0]            m_tdata,
    input  wire pidc_pkg::cmd_t    cmd,
    output pidc_pkg::status_t      status
);
    import pidc_pkg::*;

    logic signed [23:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic signed [31:0] setpoint_reg;
    logic [30:0]        drive_limit_reg;

    logic signed [31:0] meas_reg;
    logic [15:0]        dt_reg;
    logic signed [31:0] err_reg, prev_error_reg, integ_sum_reg, deriv_hold_reg;
    logic signed [47:0] idt_reg;
    logic signed [43:0] dscl_reg;
    logic               div_neg_reg;
    logic signed [55:0] prod_reg;
    logic signed [57:0] acc_reg;
    logic signed [31:0] y_reg;
    logic               m_tvalid_reg;
    logic [31:0]        m_tdata_reg;

    logic signed [32:0] err_wide;
    logic signed [31:0] err_sat;
    logic signed [48:0] idt_full;
    logic signed [32:0] ddiff;
    logic signed [49:0] dscl_full;
    logic [47:0]        idt_mag;
    logic [43:0]        dscl_mag;
    logic [47:0]        div_dividend;
    logic [15:0]        div_divisor;
    logic               div_neg;
    logic               div_done;
    logic [47:0]        div_quo;
    logic signed [47:0] quo_s;
    logic signed [47:0] integ_wide;
    logic signed [31:0] integ_clamp;
    logic signed [31:0] deriv_sat;
    logic signed [23:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [55:0] mul_p;
    logic signed [41:0] y_sh;
    logic signed [41:0] lim_pos;
    logic signed [41:0] lim_neg;
    logic signed [31:0] y_clamp;

    assign err_wide = {setpoint_reg[31], setpoint_reg} - {meas_reg[31], meas_reg};

    always_comb begin
        if (err_wide[32] != err_wide[31]) begin
            err_sat = err_wide[32] ? S32_MIN : S32_MAX;
        end else begin
            err_sat = err_wide[31:0];
        end
    end

    assign idt_full  = err_reg * $signed({1'b0, dt_reg});
    assign ddiff     = {err_reg[31], err_reg} - {prev_error_reg[31], prev_error_reg};
    assign dscl_full = ddiff * $signed({1'b0, MS_PER_S});
    assign idt_mag   = idt_reg[47] ? -idt_reg : idt_reg;
    assign dscl_mag  = dscl_reg[43] ? -dscl_reg : dscl_reg;

    always_comb begin
        if (cmd.div_sel == DIV_DERIV) begin
            div_neg      = dscl_reg[43];
            div_dividend = {4'b0, dscl_mag};
            div_divisor  = dt_reg;
        end else begin
            div_neg      = idt_reg[47];
            div_dividend = idt_mag;
            div_divisor  = MS_PER_S;
        end
    end

    pidc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign quo_s      = div_neg_reg ? -$signed(div_quo) : $signed(div_quo);
    assign integ_wide = 48'(integ_sum_reg) + quo_s;

    always_comb begin
        if (integ_wide >= 48'(INTEG_LIMIT)) begin
            integ_clamp = INTEG_LIMIT;
        end else if (integ_wide <= -48'(INTEG_LIMIT)) begin
            integ_clamp = -INTEG_LIMIT;
        end else begin
            integ_clamp = integ_wide[31:0];
        end
    end

    always_comb begin
        if (quo_s > 48'(S32_MAX)) begin
            deriv_sat = S32_MAX;
        end else if (quo_s < 48'(S32_MIN)) begin
            deriv_sat = S32_MIN;
        end else begin
            deriv_sat = quo_s[31:0];
        end
    end

    always_comb begin
        case (cmd.mul_sel)
            GAIN_P: begin
                mul_a = prop_gain_reg;
                mul_b = err_reg;
            end
            GAIN_I: begin
                mul_a = integ_gain_reg;
                mul_b = integ_sum_reg;
            end
            default: begin
                mul_a = deriv_gain_reg;
                mul_b = deriv_hold_reg;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign y_sh    = $signed(acc_reg[57:16]);
    assign lim_pos = $signed({11'b0, drive_limit_reg});
    assign lim_neg = -lim_pos;

    always_comb begin
        if (y_sh >= lim_pos) begin
            y_clamp = lim_pos[31:0];
        end else if (y_sh <= lim_neg) begin
            y_clamp = lim_neg[31:0];
        end else begin
            y_clamp = y_sh[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg   <= '0;
            integ_gain_reg  <= '0;
            deriv_gain_reg  <= '0;
            setpoint_reg    <= '0;
            drive_limit_reg <= LIMIT_RESET;
            prev_error_reg  <= '0;
            integ_sum_reg   <= '0;
            deriv_hold_reg  <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_PROP_GAIN:   prop_gain_reg   <= cfg_wdata[23:0];
                    REG_INTEG_GAIN:  integ_gain_reg  <= cfg_wdata[23:0];
                    REG_DERIV_GAIN:  deriv_gain_reg  <= cfg_wdata[23:0];
                    REG_SETPOINT:    setpoint_reg    <= cfg_wdata;
                    REG_DRIVE_LIMIT: drive_limit_reg <= cfg_wdata[30:0];
                    default: begin
                    end
                endcase
            end
            if (cmd.integ_upd) begin
                integ_sum_reg <= integ_clamp;
            end
            if (cmd.deriv_upd) begin
                deriv_hold_reg <= deriv_sat;
            end
            if (cmd.out_load) begin
                prev_error_reg <= err_reg;
                m_tvalid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            meas_reg <= s_tdata[31:0];
            dt_reg   <= s_tdata[47:32];
        end
        if (cmd.calc_err) begin
            err_reg <= err_sat;
        end
        if (cmd.calc_prods) begin
            idt_reg  <= idt_full[47:0];
            dscl_reg <= dscl_full[43:0];
        end
        if (cmd.div_start) begin
            div_neg_reg <= div_neg;
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_p;
        end
        if (cmd.acc_ld) begin
            acc_reg <= 58'(prod_reg);
        end else if (cmd.acc_add) begin
            acc_reg <= acc_reg + 58'(prod_reg);
        end
        if (cmd.clamp_en) begin
            y_reg <= y_clamp;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= y_reg;
        end
    end

    assign status.div_done = div_done;
    assign status.dt_zero  = (dt_reg == 16'd0);
    assign status.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/pidc_ctrl.sv -----
// Sequencer of the clamped PID controller.
`default_nettype none

module pidc_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output pidc_pkg::cmd_t         cmd,
    input  wire pidc_pkg::status_t status
);
    import pidc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ERR   = 4'd1;
    localparam logic [3:0] S_PROD  = 4'd2;
    localparam logic [3:0] S_DIVI  = 4'd3;
    localparam logic [3:0] S_WAITI = 4'd4;
    localparam logic [3:0] S_DIVD  = 4'd5;
    localparam logic [3:0] S_WAITD = 4'd6;
    localparam logic [3:0] S_MULP  = 4'd7;
    localparam logic [3:0] S_MULI  = 4'd8;
    localparam logic [3:0] S_MULD  = 4'd9;
    localparam logic [3:0] S_SUM   = 4'd10;
    localparam logic [3:0] S_CLAMP = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_ERR;
                end
            end
            S_ERR: begin
                cmd.calc_err = 1'b1;
                state_next   = S_PROD;
            end
            S_PROD: begin
                cmd.calc_prods = 1'b1;
                state_next     = S_DIVI;
            end
            S_DIVI: begin
                if (status.dt_zero) begin
                    state_next = S_MULP;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_INTEG;
                    state_next    = S_WAITI;
                end
            end
            S_WAITI: begin
                if (status.div_done) begin
                    cmd.integ_upd = 1'b1;
                    state_next    = S_DIVD;
                end
            end
            S_DIVD: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_DERIV;
                state_next    = S_WAITD;
            end
            S_WAITD: begin
                if (status.div_done) begin
                    cmd.deriv_upd = 1'b1;
                    state_next    = S_MULP;
                end
            end
            S_MULP: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = GAIN_P;
                state_next  = S_MULI;
            end
            S_MULI: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = GAIN_I;
                cmd.acc_ld  = 1'b1;
                state_next  = S_MULD;
            end
            S_MULD: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = GAIN_D;
                cmd.acc_add = 1'b1;
                state_next  = S_SUM;
            end
            S_SUM: begin
                cmd.acc_add = 1'b1;
                state_next  = S_CLAMP;
            end
            S_CLAMP: begin
                cmd.clamp_en = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

`default_nettype wire

// ----- hw/rtl/pid_controller_clamped_core.sv -----
// Top level of the clamped PID controller.
//
// One input transfer on the s_ channel carries a measured value and the
// milliseconds elapsed since the previous step; each produces exactly one
// clamped drive value on the m_ channel. Gains, setpoint and drive limit are
// written through the cfg_ port, one register per write; the user must write
// them only while no step is in progress, which the block itself does not enforce.
// When elapsed_ms is non-zero, a step runs the shared divider twice: once for
// the integral increment and once for the derivative. The divider yields two
// quotient bits per cycle. When elapsed_ms is zero, both divisions are
// skipped and the integral and derivative keep their previous values.
// s_tready is high only while no step is in progress. The result waits in
// an output register; a new step may be accepted while it waits, but that
// step is not completed until the receiver has taken the earlier result.
// Reset clears the integral, derivative and previous error, restores the
// register defaults and empties the output register.
`default_nettype none

module pid_controller_clamped_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // measured [31:0], elapsed_ms [47:32]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // drive [31:0]
);
    import pidc_pkg::*;

    cmd_t    cmd;
    status_t status;

    pidc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    pidc_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/pidc_checker.sv -----
// Port-level checker of the clamped PID controller and its bind.
`default_nettype none
`include "pid_controller_clamped_core_macros.svh"

module pidc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    `PIDC_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "Stalled result changed or vanished.")
    `PIDC_ASSERT_NXT(a_one_step, aclk, aresetn, s_tvalid && s_tready, !s_tready, "Input accepted again before the step finished.")
    `PIDC_ASSERT_IMP(a_symmetric, aclk, aresetn, m_tvalid, m_tdata != 32'h8000_0000, "Drive outside the symmetric clamp range.")
    `PIDC_ASSERT_RST(a_reset_state, aclk, !aresetn, !m_tvalid && s_tready, "Block not idle and empty after reset.")

endmodule

bind pid_controller_clamped_core pidc_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- verif/tb_pid_controller_clamped_core.sv -----
// Self-checking testbench of the clamped PID controller with a predicting scoreboard.
`timescale 1ns / 100ps

module tb_pid_controller_clamped_core;
    import pidc_pkg::*;

    class pid_drive_scoreboard;
        logic signed [23:0] kp;
        logic signed [23:0] ki;
        logic signed [23:0] kd;
        logic signed [31:0] target;
        logic [30:0]        limit;
        longint             prev_err;
        longint             integ;
        longint             deriv;
        logic [31:0]        drive_q[$];
        int                 mismatches;

        function new();
            kp = '0;
            ki = '0;
            kd = '0;
            target = '0;
            limit = LIMIT_RESET;
            prev_err = 0;
            integ = 0;
            deriv = 0;
            mismatches = 0;
        endfunction

        function longint sat32(longint v);
            if (v > longint'(S32_MAX)) return longint'(S32_MAX);
            if (v < longint'(S32_MIN)) return longint'(S32_MIN);
            return v;
        endfunction

        function int pending();
            return drive_q.size();
        endfunction

        function void configure(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_PROP_GAIN:   kp = value[23:0];
                REG_INTEG_GAIN:  ki = value[23:0];
                REG_DERIV_GAIN:  kd = value[23:0];
                REG_SETPOINT:    target = value;
                REG_DRIVE_LIMIT: limit = value[30:0];
                default: ;
            endcase
        endfunction

        function void note_input(logic signed [31:0] meas, logic [15:0] dt);
            longint err;
            longint acc;
            longint y;
            longint lim;
            err = sat32(longint'(target) - longint'(meas));
            if (dt != 0)
                deriv = sat32(((err - prev_err) * longint'(MS_PER_S)) / longint'(dt));
            integ += (err * longint'(dt)) / longint'(MS_PER_S);
            if (integ >= longint'(INTEG_LIMIT))
                integ = longint'(INTEG_LIMIT);
            else if (integ <= -longint'(INTEG_LIMIT))
                integ = -longint'(INTEG_LIMIT);
            prev_err = err;
            acc = longint'(kp) * err + longint'(ki) * integ + longint'(kd) * deriv;
            y = acc >>> 16;
            lim = longint'(limit);
            if (y >= lim)
                y = lim;
            else if (y <= -lim)
                y = -lim;
            drive_q.push_back(32'(y));
        endfunction

        function void check_result(logic [31:0] drive);
            logic [31:0] want;
            if (drive_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: drive %h arrived with no step outstanding",
                             $realtime, drive);
            end else begin
                want = drive_q.pop_front();
                if (drive !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: drive expected %h, got %h", $realtime, want, drive);
                end
            end
        endfunction
    endclass

    localparam int STEP_LATENCY    = 61;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int N_PHASES        = 12;
    localparam int ITEMS_PER_PHASE = 160;
    localparam logic [2:0] REG_UNMAPPED = 3'd5;

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // measured [31:0], elapsed_ms [47:32]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // drive [31:0]

    rx_mode_t    rx_mode = RX_ALWAYS;
    int unsigned rx_cycle = 0;
    int unsigned rx_hold = 0;
    int unsigned cycle_count = 0;

    pid_drive_scoreboard sb;

    pid_controller_clamped_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 256 == 0)
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_ALWAYS: m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default: begin
                if (rx_hold == 0) begin
                    m_tready <= !m_tready;
                    rx_hold <= m_tready ? $urandom_range(20, 80) : $urandom_range(1, 4);
                end else begin
                    rx_hold <= rx_hold - 1;
                end
            end
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    task automatic program_regs(input logic [31:0] pg, input logic [31:0] ig,
                                input logic [31:0] dg, input logic [31:0] sp,
                                input logic [31:0] lim, input bit poke_unmapped);
        logic [2:0]  idx [5];
        logic [31:0] val [5];
        logic [2:0]  junk_idx;
        logic [31:0] junk_val;
        idx = '{REG_PROP_GAIN, REG_INTEG_GAIN, REG_DERIV_GAIN, REG_SETPOINT, REG_DRIVE_LIMIT};
        val = '{pg, ig, dg, sp, lim};
        for (int i = 0; i < 5; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge aclk);
            sb.configure(idx[i], val[i]);
        end
        if (poke_unmapped) begin
            junk_idx = 3'(REG_UNMAPPED + $urandom_range(0, 2));
            junk_val = $urandom;
            cfg_index <= junk_idx;
            cfg_wdata <= junk_val;
            @(posedge aclk);
            sb.configure(junk_idx, junk_val);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_item(input logic [31:0] meas, input logic [15:0] dt);
        s_tvalid <= 1'b1;
        s_tdata <= {dt, meas};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(meas, dt);
    endtask

    task automatic hold_off(input int unsigned cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic drain(input bit settle);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        if (settle)
            repeat (STEP_LATENCY + 8) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_gain();
        logic [23:0] g;
        case ($urandom_range(0, 5))
            0:       g = 24'h7FFFFF;
            1:       g = 24'h800000;
            2:       g = '0;
            3:       g = 24'($urandom);
            default: g = 24'($urandom_range(0, 524288) - 262144);
        endcase
        return {8'($urandom), g};
    endfunction

    initial begin
        logic [31:0] sp;
        logic [31:0] lim;
        logic [31:0] meas;
        logic [15:0] dt;
        int          sent;
        int          burst;

        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Register defaults: zero gains give zero drive while the state still moves.
        send_item(32'h0000_0000, 16'd0);
        send_item(S32_MAX, 16'hFFFF);
        send_item(S32_MIN, 16'd1);
        drain(1);

        // Unity gains, upper bits of each write to be dropped.
        program_regs(32'hA501_0000, 32'h5A01_0000, 32'hFF01_0000, 32'h0005_0000,
                     32'h8000_0000 | 32'(LIMIT_RESET), 1'b0);
        send_item(32'h0000_0000, 16'd10);
        send_item(32'h0003_0000, 16'd10);
        send_item(32'h0003_0000, 16'd0);
        send_item(32'h000A_0000, 16'd1000);
        send_item(32'hFF9C_0000, 16'hFFFF);
        send_item(32'h0064_0000, 16'hFFFF);
        drain(1);

        // Extreme gains: error, derivative and output all saturate.
        program_regs(32'h007F_FFFF, 32'h0080_0000, 32'h007F_FFFF, S32_MAX,
                     32'hFFFF_FFFF, 1'b0);
        send_item(S32_MIN, 16'd1);
        send_item(S32_MAX, 16'd1);
        send_item(32'h0000_0000, 16'd0);
        send_item(S32_MIN, 16'hFFFF);
        drain(1);

        // Zero drive limit, negative error saturation, unmapped register write.
        program_regs(32'h0000_0001, 32'h0000_0000, 32'h00FF_FFFF, S32_MIN,
                     32'h0000_0000, 1'b1);
        send_item(S32_MAX, 16'd1);
        send_item(32'h0000_0000, 16'd0);
        drain(1);

        // Smallest gain: a negative fraction must round towards minus infinity.
        program_regs(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                     32'(LIMIT_RESET), 1'b1);
        send_item(32'h0000_0001, 16'd0);
        send_item(32'hFFFF_FFFF, 16'd0);
        drain(1);

        for (int phase = 0; phase < N_PHASES; phase++) begin
            case ($urandom_range(0, 3))
                0:       sp = $urandom;
                1:       sp = ($urandom_range(0, 1) != 0) ? S32_MAX : S32_MIN;
                default: sp = $urandom_range(0, 32'h0064_0000) - 32'h0032_0000;
            endcase
            case ($urandom_range(0, 5))
                0:       lim = '0;
                1:       lim = 32'(LIMIT_RESET);
                2:       lim = 32'hFFFF_FFFF;
                3:       lim = $urandom;
                default: lim = $urandom_range(1, 32'h00C8_0000);
            endcase
            program_regs(pick_gain(), pick_gain(), pick_gain(), sp, lim,
                         $urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                burst = $urandom_range(1, 16);
                repeat (burst) begin
                    case ($urandom_range(0, 15))
                        0:       meas = ($urandom_range(0, 1) != 0) ? S32_MAX : S32_MIN;
                        1, 2:    meas = $urandom;
                        default: meas = sp + $urandom_range(0, 32'h0028_0000) - 32'h0014_0000;
                    endcase
                    case ($urandom_range(0, 15))
                        0, 1:    dt = '0;
                        2:       dt = 16'hFFFF;
                        3, 4:    dt = 16'($urandom);
                        default: dt = 16'($urandom_range(1, 50));
                    endcase
                    send_item(meas, dt);
                    sent++;
                end
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: ;
                    9:          drain(0);
                    default:    hold_off($urandom_range(1, 40));
                endcase
            end
            drain(1);
        end

        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/pidc_pkg.sv
hw/rtl/pidc_div.sv
hw/rtl/pidc_dpath.sv
hw/rtl/pidc_ctrl.sv
hw/rtl/pid_controller_clamped_core.sv
hw/rtl/pidc_checker.sv
verif/tb_pid_controller_clamped_core.sv
